[rtl/core/acrn_pkg.sv]
// ----------------------------------------------------------------------------
// acrn_pkg: shared types and constants for the audio caps record negotiator
// Record layout, codec and kind codes, register indexes and transfer structs.
// ----------------------------------------------------------------------------
package acrn_pkg;

  localparam int unsigned CountW = 4;

  // record byte positions
  localparam logic [CountW-1:0] PosKind   = 4'd4;
  localparam logic [CountW-1:0] PosCodecs = 4'd5;
  localparam logic [CountW-1:0] PosRates  = 4'd6;
  localparam logic [CountW-1:0] PosPad0   = 4'd7;
  localparam logic [CountW-1:0] PosMaxHi  = 4'd8;
  localparam logic [CountW-1:0] PosMaxLo  = 4'd9;
  localparam logic [CountW-1:0] PosPad1   = 4'd10;
  localparam logic [CountW-1:0] PosLast   = 4'd11;
  localparam logic [CountW-1:0] CountMax  = 4'd15;

  // magic "KAC1"
  localparam logic [7:0] Magic0 = 8'h4B;
  localparam logic [7:0] Magic1 = 8'h41;
  localparam logic [7:0] Magic2 = 8'h43;
  localparam logic [7:0] Magic3 = 8'h31;

  localparam logic [7:0] KindOffer   = 8'd0;
  localparam logic [7:0] KindAnswer  = 8'd1;
  localparam logic [7:0] KindDecline = 8'd2;

  localparam logic [1:0] PickAnswer  = 2'd1;
  localparam logic [1:0] PickDecline = 2'd2;

  localparam logic [1:0] CodecNone = 2'd0;
  localparam logic [1:0] CodecPcm  = 2'd1;
  localparam logic [1:0] CodecComp = 2'd2;

  localparam logic [1:0] ModeForcePcm  = 2'd1;
  localparam logic [1:0] ModeForceComp = 2'd2;

  localparam logic [3:0] Kbps3  = 4'd3;
  localparam logic [3:0] Kbps6  = 4'd6;
  localparam logic [3:0] Kbps12 = 4'd12;

  // configuration register indexes
  localparam logic [1:0] RegAudioMode   = 2'd0;
  localparam logic [1:0] RegBitrate     = 2'd1;
  localparam logic [1:0] RegCodecReady  = 2'd2;
  localparam logic [1:0] RegPacketLimit = 2'd3;

  typedef struct packed {
    logic [1:0]  audio_mode;
    logic [3:0]  bitrate_kbps;
    logic        codec_ready;
    logic [15:0] packet_limit;
  } acrn_cfg_t;

  typedef struct packed {
    logic        record_ok;
    logic [7:0]  rec_kind;
    logic [7:0]  rec_codecs;
    logic [7:0]  rec_rates;
    logic [15:0] rec_maximum;
    logic [1:0]  pick_kind;
    logic [1:0]  pick_codecs;
    logic [2:0]  pick_rates;
    logic [15:0] pick_maximum;
  } acrn_result_t;

  function automatic logic [2:0] rate_bit(input logic [3:0] kbps);
    logic [2:0] rb;
    case (kbps)
      Kbps3:   rb = 3'd1;
      Kbps6:   rb = 3'd2;
      Kbps12:  rb = 3'd4;
      default: rb = 3'd0;
    endcase
    return rb;
  endfunction

endpackage

[rtl/core/acrn_parse.sv]
// ----------------------------------------------------------------------------
// acrn_parse: record byte parser and reply picker
// Holds the per-record state and forms the result on the last byte.
// ----------------------------------------------------------------------------
module acrn_parse
  import acrn_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   rec_byte,
  input  logic         rec_last,
  input  acrn_cfg_t    cfg,
  output logic         res_valid,
  output acrn_result_t res
);

  logic [CountW-1:0] count_r, count_nxt;
  logic              bad_r, bad_nxt;
  logic [7:0]        kind_r, kind_nxt;
  logic [7:0]        codecs_r, codecs_nxt;
  logic [7:0]        rates_r, rates_nxt;
  logic [15:0]       max_r, max_nxt;

  // values after this byte is folded in
  logic [7:0]  kind_u, codecs_u, rates_u;
  logic [15:0] max_u;
  logic        bad_u, ok_base, ok, single_rate, max_fits;
  logic        pcm_ok, comp_ok;
  logic [2:0]  rb;

  always_comb begin
    kind_u   = kind_r;
    codecs_u = codecs_r;
    rates_u  = rates_r;
    max_u    = max_r;
    bad_u    = bad_r;
    case (count_r)
      4'd0:      bad_u = bad_r | (rec_byte != Magic0);
      4'd1:      bad_u = bad_r | (rec_byte != Magic1);
      4'd2:      bad_u = bad_r | (rec_byte != Magic2);
      4'd3:      bad_u = bad_r | (rec_byte != Magic3);
      PosKind: begin
        kind_u = rec_byte;
        bad_u  = bad_r | (rec_byte > KindDecline);
      end
      PosCodecs: codecs_u = rec_byte;
      PosRates:  rates_u  = rec_byte;
      PosMaxHi:  max_u    = {rec_byte, max_r[7:0]};
      PosMaxLo:  max_u    = {max_r[15:8], rec_byte};
      PosPad0, PosPad1, PosLast: bad_u = bad_r | (rec_byte != 8'd0);
      default:   bad_u = 1'b1;
    endcase
  end

  always_comb begin
    max_fits    = max_u >= cfg.packet_limit;
    single_rate = (rates_u == 8'd1) || (rates_u == 8'd2) || (rates_u == 8'd4);
    pcm_ok      = (codecs_u == {6'd0, CodecPcm}) && (rates_u == 8'd0);
    comp_ok     = (codecs_u == {6'd0, CodecComp}) && single_rate && max_fits;
    ok_base     = !bad_u && (count_r == PosLast);
    ok          = ok_base;
    if (kind_u == KindAnswer && !pcm_ok && !comp_ok) begin
      ok = 1'b0;
    end
    if (kind_u == KindDecline && (codecs_u != 8'd0 || rates_u != 8'd0 || max_u != 16'd0)) begin
      ok = 1'b0;
    end
    rb = rate_bit(cfg.bitrate_kbps);

    res.record_ok    = ok;
    res.rec_kind     = kind_u;
    res.rec_codecs   = codecs_u;
    res.rec_rates    = rates_u;
    res.rec_maximum  = max_u;
    res.pick_kind    = PickDecline;
    res.pick_codecs  = CodecNone;
    res.pick_rates   = 3'd0;
    res.pick_maximum = 16'd0;
    if (ok && kind_u == KindOffer) begin
      if (cfg.audio_mode != ModeForcePcm && cfg.codec_ready && codecs_u[1]
          && ((rates_u[2:0] & rb) != 3'd0) && max_fits) begin
        res.pick_kind    = PickAnswer;
        res.pick_codecs  = CodecComp;
        res.pick_rates   = rb;
        res.pick_maximum = cfg.packet_limit;
      end else if (cfg.audio_mode != ModeForceComp && codecs_u[0]) begin
        res.pick_kind   = PickAnswer;
        res.pick_codecs = CodecPcm;
      end
    end
  end

  assign res_valid = take && rec_last;

  always_comb begin
    count_nxt  = count_r;
    bad_nxt    = bad_r;
    kind_nxt   = kind_r;
    codecs_nxt = codecs_r;
    rates_nxt  = rates_r;
    max_nxt    = max_r;
    if (take) begin
      if (rec_last) begin
        // record closed, start over
        count_nxt  = '0;
        bad_nxt    = 1'b0;
        kind_nxt   = '0;
        codecs_nxt = '0;
        rates_nxt  = '0;
        max_nxt    = '0;
      end else begin
        count_nxt  = (count_r == CountMax) ? CountMax : count_r + 4'd1;
        bad_nxt    = bad_u;
        kind_nxt   = kind_u;
        codecs_nxt = codecs_u;
        rates_nxt  = rates_u;
        max_nxt    = max_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      bad_r    <= 1'b0;
      kind_r   <= '0;
      codecs_r <= '0;
      rates_r  <= '0;
      max_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      bad_r    <= bad_nxt;
      kind_r   <= kind_nxt;
      codecs_r <= codecs_nxt;
      rates_r  <= rates_nxt;
      max_r    <= max_nxt;
    end
  end

endmodule

[rtl/core/audio_caps_record_negotiator_core.sv]
// ----------------------------------------------------------------------------
// audio_caps_record_negotiator_core: capability record checker and negotiator
// Parses 12-byte audio capability records and issues one reply per record.
// ----------------------------------------------------------------------------
// One record byte is taken per clock while in_stall is low; every byte is
// checked as it arrives and the byte marked last produces one result in the
// output register, or in the skid slot if that is full. A second result slot
// behind the output register lets bytes keep flowing while a result waits;
// in_stall rises only when both slots hold results. Bytes that are not last
// produce no result and never wait on the output side unless both slots are
// full. Configuration writes are always ready and apply once registered.
module audio_caps_record_negotiator_core
  import acrn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_record_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_ok,
  output logic [7:0]  out_rec_kind,
  output logic [7:0]  out_rec_codecs,
  output logic [7:0]  out_rec_rates,
  output logic [15:0] out_rec_maximum,
  output logic [1:0]  out_pick_kind,
  output logic [1:0]  out_pick_codecs,
  output logic [2:0]  out_pick_rates,
  output logic [15:0] out_pick_maximum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  acrn_cfg_t    cfg_r, cfg_nxt;
  acrn_result_t res, out_r, out_nxt, skid_r, skid_nxt;
  logic         out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic         take, res_valid, out_take;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        RegAudioMode:   cfg_nxt.audio_mode   = cfg_data[1:0];
        RegBitrate:     cfg_nxt.bitrate_kbps = cfg_data[3:0];
        RegCodecReady:  cfg_nxt.codec_ready  = cfg_data[0];
        RegPacketLimit: cfg_nxt.packet_limit = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign take     = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  acrn_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rec_byte  (in_record_byte),
    .rec_last  (in_last_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register with one skid slot behind it
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.audio_mode   <= 2'd0;
      cfg_r.bitrate_kbps <= Kbps6;
      cfg_r.codec_ready  <= 1'b0;
      cfg_r.packet_limit <= 16'd1024;
      out_valid_r        <= 1'b0;
      skid_valid_r       <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_record_ok    = out_r.record_ok;
  assign out_rec_kind     = out_r.rec_kind;
  assign out_rec_codecs   = out_r.rec_codecs;
  assign out_rec_rates    = out_r.rec_rates;
  assign out_rec_maximum  = out_r.rec_maximum;
  assign out_pick_kind    = out_r.pick_kind;
  assign out_pick_codecs  = out_r.pick_codecs;
  assign out_pick_rates   = out_r.pick_rates;
  assign out_pick_maximum = out_r.pick_maximum;

endmodule

[rtl/core/acrn_checker.sv]
// ----------------------------------------------------------------------------
// acrn_checker: port-level checks for the negotiator core
// Watches the channels and the reply fields over time.
// ----------------------------------------------------------------------------
module acrn_checker
  import acrn_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_ok,
  input logic [7:0]  out_rec_kind,
  input logic [7:0]  out_rec_codecs,
  input logic [7:0]  out_rec_rates,
  input logic [15:0] out_rec_maximum,
  input logic [1:0]  out_pick_kind,
  input logic [1:0]  out_pick_codecs,
  input logic [2:0]  out_pick_rates,
  input logic [15:0] out_pick_maximum
);

  // input is held back only while a result is pending
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // a last-byte transfer into an empty output shows a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte && !out_valid) |=> out_valid)
    else $error("last byte produced no result");

  // a mid-record transfer never invents a result
  a_mid_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_last_byte && !out_valid) |=> !out_valid)
    else $error("result without a last byte");

  // rejected records always get a plain decline
  a_reject_declines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_record_ok) |->
      (out_pick_kind == PickDecline && out_pick_codecs == CodecNone &&
       out_pick_rates == 3'd0 && out_pick_maximum == 16'd0))
    else $error("rejected record did not decline");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_record_ok) &&
      $stable(out_rec_kind) && $stable(out_rec_codecs) && $stable(out_rec_rates) &&
      $stable(out_rec_maximum) && $stable(out_pick_kind) &&
      $stable(out_pick_codecs) && $stable(out_pick_rates) &&
      $stable(out_pick_maximum)))
    else $error("stalled result changed");

endmodule

bind audio_caps_record_negotiator_core acrn_checker u_acrn_checker (.*);
